[rtl/core/plb_pkg.sv]
// Package: constants, codes and word types for the positional list buffer.
`default_nettype none
package plb_pkg;

	localparam int DEPTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 16;
	localparam int VALUE_W = 64;
	localparam int STAT_W  = 2;
	localparam int ECNT_W  = 6;

	localparam int IN_FIELDS_W = FUNC_W + POS_W + VALUE_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = VALUE_W + STAT_W + ECNT_W;

	localparam logic [VALUE_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_LAST   = 3'd2,
		FN_INSERT = 3'd3,
		FN_REMOVE = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	typedef struct packed {
		func_t              func;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [ECNT_W-1:0]  entry_count;
		stat_t              status;
		logic [VALUE_W-1:0] read_value;
	} res_t;

endpackage
`default_nettype wire

[rtl/core/plb_store.sv]
// Entry register array, entry count and the per-request list update.
`default_nettype none
module plb_store (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  plb_pkg::req_t       req,
	output plb_pkg::res_t       res
);

	logic [plb_pkg::VALUE_W-1:0] ents_q [plb_pkg::DEPTH];
	logic [plb_pkg::VALUE_W-1:0] ents_d [plb_pkg::DEPTH];
	logic [plb_pkg::DEPTH-1:0]   ents_we;
	logic [plb_pkg::CNT_W-1:0]   count_q;
	logic [plb_pkg::CNT_W-1:0]   count_d;
	logic [plb_pkg::CNT_W-1:0]   cnt_m1;
	logic [plb_pkg::CNT_W-1:0]   ins_loc;
	logic [plb_pkg::CNT_W-1:0]   rm_pos;
	logic                        full;
	logic                        empty;
	logic                        pos_below;
	logic                        do_ins;
	logic                        do_rm;

	assign full      = (count_q == plb_pkg::CNT_W'(plb_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign pos_below = (req.pos < plb_pkg::POS_W'(count_q));
	assign cnt_m1    = count_q - 1'b1;
	assign rm_pos    = plb_pkg::CNT_W'(req.pos);

	always_comb begin
		count_d        = count_q;
		do_ins         = 1'b0;
		do_rm          = 1'b0;
		ins_loc        = count_q;
		res.read_value = '0;
		res.status     = plb_pkg::ST_OK;
		case (req.func)
			plb_pkg::FN_PUSH: begin
				if (full) begin
					res.status = plb_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			plb_pkg::FN_POP: begin
				if (empty) begin
					res.status = plb_pkg::ST_EMPTY;
				end else begin
					count_d = cnt_m1;
				end
			end
			plb_pkg::FN_LAST: begin
				if (empty) begin
					res.status     = plb_pkg::ST_EMPTY;
					res.read_value = plb_pkg::QNAN_BITS;
				end else begin
					res.read_value = ents_q[cnt_m1[plb_pkg::IDX_W-1:0]];
				end
			end
			plb_pkg::FN_INSERT: begin
				if (full) begin
					res.status = plb_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					ins_loc = pos_below ? rm_pos : count_q;
					count_d = count_q + 1'b1;
				end
			end
			plb_pkg::FN_REMOVE: begin
				if (!pos_below) begin
					res.status = plb_pkg::ST_RANGE;
				end else begin
					do_rm   = 1'b1;
					count_d = cnt_m1;
				end
			end
			plb_pkg::FN_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		res.entry_count = plb_pkg::ECNT_W'(count_d);
	end

	for (genvar g = 0; g < plb_pkg::DEPTH; g++) begin : g_ent
		logic [plb_pkg::VALUE_W-1:0] prev_v;
		logic [plb_pkg::VALUE_W-1:0] next_v;
		logic                        has_prev;
		logic                        has_next;
		logic [plb_pkg::CNT_W-1:0]   idx;

		assign idx = plb_pkg::CNT_W'(g);
		if (g > 0) begin : g_prev
			assign prev_v   = ents_q[g-1];
			assign has_prev = 1'b1;
		end else begin : g_noprev
			assign prev_v   = ents_q[g];
			assign has_prev = 1'b0;
		end
		if (g < plb_pkg::DEPTH - 1) begin : g_next
			assign next_v   = ents_q[g+1];
			assign has_next = 1'b1;
		end else begin : g_nonext
			assign next_v   = ents_q[g];
			assign has_next = 1'b0;
		end

		always_comb begin
			ents_we[g] = 1'b0;
			ents_d[g]  = req.item_value;
			if (do_ins) begin
				if (idx == ins_loc) begin
					ents_we[g] = 1'b1;
				end else if (has_prev && idx > ins_loc && idx <= count_q) begin
					ents_we[g] = 1'b1;
					ents_d[g]  = prev_v;
				end
			end else if (do_rm) begin
				if (has_next && idx >= rm_pos && (idx + 1'b1) < count_q) begin
					ents_we[g] = 1'b1;
					ents_d[g]  = next_v;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (fire && ents_we[g]) begin
				ents_q[g] <= ents_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/positional_list_buffer_unit.sv]
// Top level of the positional list buffer: input register, list store, result register.
//
// An ordered list of up to 32 64-bit words with an entry count.
// Request channel s_*: one word per request, fields func, pos, item_value.
// Result channel m_*: exactly one word per request, in request order, with
// read_value, status and the entry count after the request.
// A request accepted at one edge lands in the input register, is executed
// against the list combinationally and its result is registered once the
// result register can advance; the result then shows on m_tvalid.
// Throughput is one request per cycle unless a result waits with m_tready low:
// the whole list shifts in parallel through per-entry muxes, so a request is
// done combinationally between the input and result registers, and the next
// request sees the updated list. When m_tready is low with a result waiting,
// the input register still takes a request if it is empty; after that s_tready
// drops until the result is taken. Reset empties the list and drops both valid
// flags; entry contents are not cleared and are never read before being written.
`default_nettype none
module positional_list_buffer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [2:0] func, [18:3] pos, [82:19] item_value, [87:83] zero
	input  wire logic [plb_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [63:0] read_value, [65:64] status, [71:66] entry_count
	output logic [plb_pkg::OUT_DATA_W-1:0]      m_tdata
);

	plb_pkg::req_t req_s1;
	plb_pkg::res_t res;
	plb_pkg::res_t res_q;
	logic          valid_s1;
	logic          m_valid_q;
	logic          adv;
	logic          fire;

	assign adv      = !m_valid_q || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.func       <= plb_pkg::func_t'(s_tdata[plb_pkg::FUNC_W-1:0]);
			req_s1.pos        <= s_tdata[plb_pkg::FUNC_W +: plb_pkg::POS_W];
			req_s1.item_value <= s_tdata[plb_pkg::FUNC_W + plb_pkg::POS_W +: plb_pkg::VALUE_W];
		end
	end

	plb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

endmodule
`default_nettype wire

[rtl/core/plb_checker.sv]
// Port-level assertions for the positional list buffer, bound to the top level.
`default_nettype none
module plb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [plb_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [plb_pkg::ECNT_W-1:0] cnt;
	logic [plb_pkg::STAT_W-1:0] st;

	assign cnt = m_tdata[plb_pkg::VALUE_W + plb_pkg::STAT_W +: plb_pkg::ECNT_W];
	assign st  = m_tdata[plb_pkg::VALUE_W +: plb_pkg::STAT_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= plb_pkg::ECNT_W'(plb_pkg::DEPTH))
		else $error("entry count above capacity");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == plb_pkg::ST_FULL |-> cnt == plb_pkg::ECNT_W'(plb_pkg::DEPTH))
		else $error("full status with list not full");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == plb_pkg::ST_EMPTY |-> cnt == '0)
		else $error("empty status with entries held");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_tvalid && s_tready, 2) && !$past(m_tvalid) |-> !m_tvalid)
		else $error("result word with no request in flight");

endmodule

bind positional_list_buffer_unit plb_checker u_plb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
